[design/kra_pkg.sv]
// Shared constants and types for the keyed RSSI accumulate table.
package kra_pkg;
    localparam int Depth     = 64;
    localparam int IdxW      = $clog2(Depth);
    localparam int LvlW      = $clog2(Depth + 1);
    localparam int EntW      = 48 + 32 + 24 + 16;
    localparam int QDepth    = 2;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [47:0]       mac;
        logic [31:0]       tim;
        logic signed [7:0] rssi;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic               merged;
        logic [47:0]        mac;
        logic [31:0]        tim;
        logic signed [23:0] sum;
        logic [15:0]        count;
        logic [6:0]         fill;
    } t_res;
endpackage

[design/keyed_rssi_accumulate_table.sv]
// Top level of the keyed RSSI accumulate table.
// A write scans the filled entries in turn and merges into one with equal MAC and time,
// else appends; a read pops the newest entry; clear, rejected and unused items skip RAM.
// Throughput: one item at a time in the back end; the front queue holds two more.
// Reset (synchronous, active low) empties the table and queue; entry RAM is not
// cleared, as only filled entries are ever read.
module keyed_rssi_accumulate_table import kra_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_operation,
    input  logic [47:0]        i_sample_mac,
    input  logic [31:0]        i_sample_time,
    input  logic signed [7:0]  i_sample_rssi,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic               o_merged,
    output logic [47:0]        o_out_mac,
    output logic [31:0]        o_out_time,
    output logic signed [23:0] o_out_rssi_sum,
    output logic [15:0]        o_out_count,
    output logic [6:0]         o_fill_level
);
    t_cmd in_cmd, q_cmd;
    t_res res;
    logic q_valid, q_ready;

    // Pack the input transfer into one command word.
    assign in_cmd = '{op: i_operation, mac: i_sample_mac,
                      tim: i_sample_time, rssi: i_sample_rssi};

    kra_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_cmd(in_cmd),
        .o_cvalid(q_valid), .i_cready(q_ready), .o_cmd(q_cmd));

    kra_back u_back (
        .i_clk, .i_rst_n, .i_cvalid(q_valid), .o_cready(q_ready), .i_cmd(q_cmd),
        .o_valid, .i_ready, .o_res(res));

    assign o_status       = res.status;
    assign o_merged       = res.merged;
    assign o_out_mac      = res.mac;
    assign o_out_time     = res.tim;
    assign o_out_rssi_sum = res.sum;
    assign o_out_count    = res.count;
    assign o_fill_level   = res.fill;
endmodule

[design/kra_ram.sv]
// Generic single-port RAM with registered read.
module kra_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[design/kra_front.sv]
// Front end: accept items into a short command queue.
module kra_front import kra_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_cvalid,
    input  logic i_cready,
    output t_cmd o_cmd
);
    t_cmd       r_q [QDepth];
    logic [0:0] r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready  = (r_cnt != 2'(QDepth));
    assign o_cvalid = (r_cnt != 2'd0);
    assign o_cmd    = r_q[r_rp];
    assign push     = i_valid && o_ready;
    assign pop      = o_cvalid && i_cready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push) r_q[r_wp] <= i_cmd;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'(QDepth))
        else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_wp == r_rp)) else $error("queue pointers disagree");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cvalid && !i_cready) |=> $stable(o_cmd)) else $error("head moved while held");
endmodule

[design/kra_back.sv]
// Back end: scan, merge, append, pop and clear over the entry RAM.
module kra_back import kra_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cvalid,
    output logic o_cready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);
    typedef enum logic [2:0] {S_IDLE, S_RD, S_CMP, S_POP, S_OUT} t_state;
    t_state              r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [LvlW-1:0]     r_used, n_used;
    logic [IdxW-1:0]     r_idx, n_idx;
    t_res                r_res, n_res;
    logic                r_valid, n_valid;
    logic                we;
    logic [IdxW-1:0]     addr;
    logic [EntW-1:0]     wdata, rdata;
    logic [47:0]         e_mac;
    logic [31:0]         e_tim;
    logic signed [23:0]  e_sum;
    logic [15:0]         e_cnt;
    logic signed [24:0]  sum_x;
    logic signed [23:0]  sum_s;

    kra_ram #(.Width(EntW), .Depth(Depth)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata));

    assign {e_mac, e_tim, e_sum, e_cnt} = rdata;
    assign sum_x = 25'(e_sum) + 25'(r_cmd.rssi);
    assign sum_s = (sum_x > 25'sd8388607) ? 24'sd8388607 :
                   (sum_x < -25'sd8388608) ? -24'sd8388608 : sum_x[23:0];
    assign o_cready = (r_state == S_IDLE) && !r_valid;
    assign o_valid  = r_valid;
    assign o_res    = r_res;

    always_comb begin
        n_state = r_state; n_cmd = r_cmd; n_used = r_used; n_idx = r_idx;
        n_res = r_res; n_valid = r_valid;
        we = 1'b0; addr = r_idx; wdata = '0;
        if (r_valid && i_ready) n_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cvalid && o_cready) begin
                    n_cmd = i_cmd;
                    n_res = '0;
                    n_idx = '0;
                    case (i_cmd.op)
                        OP_WRITE: begin
                            if (r_used == LvlW'(Depth)) begin
                                n_res.status = ST_FULL; n_state = S_OUT;
                            end else if (r_used == '0) begin
                                n_state = S_POP; // append at slot zero
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        OP_READ: begin
                            if (r_used == '0) begin
                                n_res.status = ST_EMPTY; n_state = S_OUT;
                            end else begin
                                n_idx = IdxW'(r_used - 1'b1); n_state = S_RD;
                            end
                        end
                        OP_CLEAR: begin
                            n_used = '0; n_state = S_OUT;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_RD: n_state = S_CMP; // address held, data arrives next cycle
            S_CMP: begin
                if (r_cmd.op == OP_READ) begin
                    n_res.mac = e_mac; n_res.tim = e_tim;
                    n_res.sum = e_sum; n_res.count = e_cnt;
                    n_used = r_used - 1'b1;
                    n_state = S_OUT;
                end else if (e_mac == r_cmd.mac && e_tim == r_cmd.tim) begin
                    we = 1'b1;
                    wdata = {e_mac, e_tim, sum_s,
                             (e_cnt == 16'hFFFF) ? e_cnt : e_cnt + 16'd1};
                    n_res.merged = 1'b1;
                    n_state = S_OUT;
                end else if (LvlW'(r_idx) + 1'b1 == r_used) begin
                    n_state = S_POP;
                end else begin
                    n_idx = r_idx + 1'b1; n_state = S_RD;
                end
            end
            S_POP: begin
                we = 1'b1;
                addr = IdxW'(r_used);
                wdata = {r_cmd.mac, r_cmd.tim, 24'(r_cmd.rssi), 16'd1};
                n_used = r_used + 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_valid) begin
                    n_res.fill = 7'(r_used); n_valid = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_used <= '0; r_valid <= 1'b0;
        end else begin
            r_state <= n_state; r_used <= n_used; r_valid <= n_valid;
        end
        r_cmd <= n_cmd; r_idx <= n_idx; r_res <= n_res;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_used <= LvlW'(Depth))
        else $error("fill level beyond depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (r_used < LvlW'(Depth))) else $error("append into full table");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_used != '0)) else $error("scan of empty table");
endmodule
